// ===== src/ant_pkg.sv =====
`timescale 1ns / 1ps
package ant_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int NAME_BYTES  = 32;
  localparam int KEY_BYTES   = 31;
  localparam int KEY_W       = KEY_BYTES * 8;
  localparam int WORD_W      = 64;
  localparam int WORD3_W     = 56;
  localparam int TICK_W      = 32;
  localparam int FREQ_W      = 32;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd30000;

  typedef enum logic [1:0] {
    CMD_RENEW  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_KEY   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic expired;
    logic match;
  } cmp_res_t;

  // zero every byte after the first NUL and at or past the name limit
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic             ended;
    logic [7:0]       b;
    logic [KEY_W-1:0] k;
    ended = 1'b0;
    k     = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[i*8 +: 8];
      if (ended || i >= NAME_BYTES - 1) b = 8'd0;
      if (b == 8'd0) ended = 1'b1;
      k[i*8 +: 8] = b;
    end
    return k;
  endfunction

endpackage

// ===== src/ant_if.sv =====
`timescale 1ns / 1ps
interface ant_req_if;
  import ant_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [WORD_W-1:0]    key_word0;
  logic [WORD_W-1:0]    key_word1;
  logic [WORD_W-1:0]    key_word2;
  logic [WORD3_W-1:0]   key_word3;
  logic [FREQ_W-1:0]    freq_in;
  logic [TICK_W-1:0]    now_ticks;
  modport source (output valid, cmd, key_word0, key_word1, key_word2, key_word3,
                  freq_in, now_ticks, input ready);
  modport sink   (input valid, cmd, key_word0, key_word1, key_word2, key_word3,
                  freq_in, now_ticks, output ready);
endinterface

interface ant_rsp_if;
  import ant_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [FREQ_W-1:0]    freq_out;
  logic [WORD_W-1:0]    name_word0;
  logic [WORD_W-1:0]    name_word1;
  logic [WORD_W-1:0]    name_word2;
  logic [WORD3_W-1:0]   name_word3;
  logic                 last;
  modport source (output valid, status, freq_out, name_word0, name_word1, name_word2,
                  name_word3, last, input ready);
  modport sink   (input valid, status, freq_out, name_word0, name_word1, name_word2,
                  name_word3, last, output ready);
endinterface

interface ant_cfg_if;
  import ant_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/ant_age_cmp.sv =====
`timescale 1ns / 1ps
module ant_age_cmp
  import ant_pkg::*;
(
  input  logic [TICK_W-1:0] stamp,
  input  logic [TICK_W-1:0] now,
  input  logic [TICK_W-1:0] timeout,
  input  logic [KEY_W-1:0]  stored_key,
  input  logic [KEY_W-1:0]  key,
  output cmp_res_t          res
);

  logic [TICK_W-1:0] age;

  assign age         = now - stamp;
  assign res.expired = (stamp > now) || (age >= timeout);
  assign res.match   = (stored_key == key);

endmodule

// ===== src/aging_name_table.sv =====
`timescale 1ns / 1ps
// Name table with aging, 16 slots keyed by names of up to 31 bytes.
// req: one command per transfer (renew, lookup, list) with key, freq and tick.
// rsp: result transfers; last marks the final result of each command.
// cfg: writes timeout_ticks; always ready, write only while idle.
// Every command first walks all slots, one per cycle, through a single
// age/key compare unit: expired slots are dropped, the first match and
// the lowest free slot are recorded. S_DO then applies the command once
// the output register is free. If any slot is valid, list walks the
// slots a second time, emitting one name per valid slot and waiting
// out any stall on rsp.
// req.ready is high only while idle; the next command may enter while the
// last result still waits in the output register.
// A stalled rsp holds its result; the sequencer waits for the register.
// Reset (sync, active high) clears all valid bits and the output valid, and
// loads the timeout with 30000. Slot contents are not cleared.
module aging_name_table
  import ant_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ant_req_if.sink   req,
  ant_rsp_if.source rsp,
  ant_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DO   = 5'b00100,
    S_LIST = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t            state;
  logic [TICK_W-1:0] timeout;

  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0]   skey   [ENTRIES];
  logic [FREQ_W-1:0]  sfreq  [ENTRIES];
  logic [TICK_W-1:0]  sstamp [ENTRIES];

  logic [1:0]         cmd;
  logic [KEY_W-1:0]   key;
  logic [FREQ_W-1:0]  freq;
  logic [TICK_W-1:0]  now;
  logic [IDX_W-1:0]   idx;
  logic               hit_found;
  logic [IDX_W-1:0]   hit;
  logic [FREQ_W-1:0]  hit_freq;
  logic               free_found;
  logic [IDX_W-1:0]   free_slot;

  logic               ovalid;
  logic [2:0]         ostatus;
  logic [FREQ_W-1:0]  ofreq;
  logic [KEY_W-1:0]   oname;
  logic               olast;

  cmp_res_t           cmp;
  logic               alive;
  logic               ofree;
  logic [ENTRIES-1:0] hi;
  logic               above;

  ant_age_cmp u_cmp (
    .stamp      (sstamp[idx]),
    .now        (now),
    .timeout    (timeout),
    .stored_key (skey[idx]),
    .key        (key),
    .res        (cmp)
  );

  assign alive = valid[idx] && !cmp.expired;
  assign ofree = !ovalid || rsp.ready;
  assign hi    = valid >> idx;
  assign above = |hi[ENTRIES-1:1];

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid      = ovalid;
  assign rsp.status     = ostatus;
  assign rsp.freq_out   = ofreq;
  assign rsp.name_word0 = oname[WORD_W-1:0];
  assign rsp.name_word1 = oname[2*WORD_W-1:WORD_W];
  assign rsp.name_word2 = oname[3*WORD_W-1:2*WORD_W];
  assign rsp.name_word3 = oname[KEY_W-1:3*WORD_W];

  always_ff @(posedge clk) begin
    if (rst) timeout <= TIMEOUT_RESET;
    else if (cfg.valid && cfg.ready) timeout <= cfg.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (rsp.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd        <= req.cmd;
            key        <= norm_key({req.key_word3, req.key_word2,
                                    req.key_word1, req.key_word0});
            freq       <= req.freq_in;
            now        <= req.now_ticks;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          if (valid[idx] && cmp.expired) valid[idx] <= 1'b0;
          if (alive && cmp.match && !hit_found) begin
            hit_found <= 1'b1;
            hit       <= idx;
            hit_freq  <= sfreq[idx];
          end
          if (!alive && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= idx;
          end
          if (idx == IDX_W'(ENTRIES - 1)) state <= S_DO;
          idx <= idx + 1'b1;
        end
        S_DO: begin
          if (ofree) begin
            ovalid  <= 1'b1;
            ofreq   <= '0;
            oname   <= '0;
            olast   <= 1'b1;
            ostatus <= ST_OK;
            state   <= S_IDLE;
            if (cmd == CMD_LIST) begin
              if (valid == '0) begin
                ostatus <= ST_EMPTY;
              end else begin
                ovalid <= 1'b0;
                idx    <= '0;
                state  <= S_LIST;
              end
            end else if (cmd == CMD_UNUSED || key[7:0] == 8'd0) begin
              ostatus <= ST_BAD_KEY;
            end else if (cmd == CMD_LOOKUP) begin
              if (hit_found) ofreq <= hit_freq;
              else ostatus <= ST_NOT_FOUND;
            end else if (hit_found) begin
              sfreq[hit]  <= freq;
              sstamp[hit] <= now;
            end else if (free_found) begin
              skey[free_slot]   <= key;
              sfreq[free_slot]  <= freq;
              sstamp[free_slot] <= now;
              valid[free_slot]  <= 1'b1;
            end else begin
              ostatus <= ST_FULL;
            end
          end
        end
        S_LIST: begin
          if (!valid[idx]) begin
            idx <= idx + 1'b1;
          end else if (ofree) begin
            ovalid  <= 1'b1;
            ostatus <= ST_OK;
            ofreq   <= '0;
            oname   <= skey[idx];
            olast   <= !above;
            idx     <= idx + 1'b1;
            if (!above) state <= S_HOLD;
          end
        end
        S_HOLD: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.last = olast;

endmodule

// ===== src/ant_checker.sv =====
`timescale 1ns / 1ps
module ant_checker
  import ant_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status,
  input logic       rsp_last,
  input logic       cfg_ready
);

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg not ready");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("back-to-back command transfer");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status <= 3'(ST_EMPTY)))
    else $error("status code out of range");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != 3'(ST_OK) |-> rsp_last)
    else $error("error result not marked last");

endmodule

bind aging_name_table ant_checker u_ant_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_last   (rsp.last),
  .cfg_ready  (cfg.ready)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import ant_pkg::*;

  typedef struct {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [FREQ_W-1:0]  freq;
    logic [TICK_W-1:0]  now;
  } table_cmd_t;

  typedef struct {
    status_t            status;
    logic [FREQ_W-1:0]  freq;
    logic [KEY_W-1:0]   name;
    logic               last;
  } table_rsp_t;

  logic clk;
  logic rst;

  ant_req_if req();
  ant_rsp_if rsp();
  ant_cfg_if cfg();

  aging_name_table dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  // predictor copy of the table
  logic [TICK_W-1:0] shadow_timeout;
  logic              slot_valid [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [FREQ_W-1:0] slot_freq  [ENTRIES];
  logic [TICK_W-1:0] slot_stamp [ENTRIES];

  table_cmd_t cmd_queue[$];
  table_rsp_t expected_rsp[$];
  int         issued;
  int         taken;
  int         errors;
  int         gap;
  int         rsp_stall;
  int         long_hold;
  bit         long_hold_done;
  bit         no_idle;
  logic [TICK_W-1:0] tick;
  logic [KEY_W-1:0]  names [20];

  function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic             ended;
    k = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (raw[i*8 +: 8] == 8'd0) ended = 1'b1;
      if (!ended) k[i*8 +: 8] = raw[i*8 +: 8];
    end
    return k;
  endfunction

  function automatic void push_rsp(input status_t st, input logic [FREQ_W-1:0] f,
                                   input logic [KEY_W-1:0] nm, input logic lst);
    table_rsp_t r;
    r.status = st;
    r.freq   = f;
    r.name   = nm;
    r.last   = lst;
    expected_rsp.push_back(r);
  endfunction

  function automatic void table_predict(input table_cmd_t c);
    logic [KEY_W-1:0] k;
    int hit;
    int n;
    k = clean_key(c.key);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && (slot_stamp[i] > c.now ||
                            c.now - slot_stamp[i] >= shadow_timeout))
        slot_valid[i] = 1'b0;
    if (c.cmd == CMD_LIST) begin
      n = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i]) begin
          push_rsp(ST_OK, '0, slot_key[i], 1'b0);
          n++;
        end
      if (n == 0) push_rsp(ST_EMPTY, '0, '0, 1'b1);
      else expected_rsp[$].last = 1'b1;
      return;
    end
    if (c.cmd == CMD_UNUSED || k[7:0] == 8'd0) begin
      push_rsp(ST_BAD_KEY, '0, '0, 1'b1);
      return;
    end
    hit = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (slot_valid[i] && slot_key[i] == k) hit = i;
    if (c.cmd == CMD_LOOKUP) begin
      if (hit < 0) push_rsp(ST_NOT_FOUND, '0, '0, 1'b1);
      else push_rsp(ST_OK, slot_freq[hit], '0, 1'b1);
      return;
    end
    if (hit < 0) begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!slot_valid[i]) hit = i;
      if (hit < 0) begin
        push_rsp(ST_FULL, '0, '0, 1'b1);
        return;
      end
      slot_key[hit]   = k;
      slot_valid[hit] = 1'b1;
    end
    slot_freq[hit]  = c.freq;
    slot_stamp[hit] = c.now;
    push_rsp(ST_OK, '0, '0, 1'b1);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    table_cmd_t c;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && taken != issued) begin
      req.valid <= 1'b1;
    end else if (gap > 0) begin
      req.valid <= 1'b0;
      gap <= gap - 1;
    end else if (cmd_queue.size() > 0) begin
      c = cmd_queue.pop_front();
      req.cmd       <= c.cmd;
      req.key_word0 <= c.key[63:0];
      req.key_word1 <= c.key[127:64];
      req.key_word2 <= c.key[191:128];
      req.key_word3 <= c.key[247:192];
      req.freq_in   <= c.freq;
      req.now_ticks <= c.now;
      req.valid     <= 1'b1;
      issued <= issued + 1;
      if (no_idle) gap <= 0;
      else if ($urandom_range(0, 11) == 0) gap <= $urandom_range(20, 60);
      else gap <= $urandom_range(0, 3);
    end else begin
      req.valid <= 1'b0;
    end
  end

  // response ready, with one long hold-off while requests keep coming
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (long_hold > 0) begin
      rsp.ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (!long_hold_done && taken == 40) begin
      rsp.ready <= 1'b0;
      long_hold <= 300;
      long_hold_done <= 1'b1;
    end else if (rsp_stall > 0) begin
      rsp.ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (!no_idle) begin
        if ($urandom_range(0, 29) == 0) rsp_stall <= $urandom_range(20, 60);
        else if ($urandom_range(0, 3) == 0) rsp_stall <= $urandom_range(1, 3);
      end
    end
  end

  // monitor: predict on request transfer, check on response transfer
  always @(posedge clk) begin
    table_rsp_t e;
    if (!rst) begin
      if (cfg.valid && cfg.ready) shadow_timeout = cfg.data;
      if (req.valid && req.ready) begin
        table_cmd_t c;
        c.cmd  = req.cmd;
        c.key  = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
        c.freq = req.freq_in;
        c.now  = req.now_ticks;
        table_predict(c);
        taken <= taken + 1;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%t: unexpected result status=%0d last=%0b", $realtime,
                   rsp.status, rsp.last);
          errors++;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.status != e.status || rsp.freq_out != e.freq || rsp.last != e.last ||
              {rsp.name_word3, rsp.name_word2, rsp.name_word1, rsp.name_word0} != e.name)
          begin
            $display("%t: mismatch expected status=%0d freq=%h last=%0b name=%h",
                     $realtime, e.status, e.freq, e.last, e.name);
            $display("%t:          actual   status=%0d freq=%h last=%0b name=%h",
                     $realtime, rsp.status, rsp.freq_out, rsp.last,
                     {rsp.name_word3, rsp.name_word2, rsp.name_word1, rsp.name_word0});
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [KEY_W-1:0] rand_name(input int len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[i*8 +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] rand_bits();
    logic [KEY_W-1:0] k;
    for (int i = 0; i < KEY_BYTES; i++) k[i*8 +: 8] = 8'($urandom);
    return k;
  endfunction

  task automatic add_cmd(input logic [1:0] c, input logic [KEY_W-1:0] k,
                         input logic [FREQ_W-1:0] f, input logic [TICK_W-1:0] t);
    table_cmd_t it;
    it.cmd  = c;
    it.key  = k;
    it.freq = f;
    it.now  = t;
    cmd_queue.push_back(it);
  endtask

  task automatic add_random(input int count);
    int r;
    logic [KEY_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 24) == 0) tick = $urandom;
      else if ($urandom_range(0, 2) != 0) tick = tick + $urandom_range(1, 40);
      r = $urandom_range(0, 19);
      k = names[$urandom_range(0, 19)];
      // garbage after the terminating NUL must not matter
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < KEY_BYTES; i++)
          if (k[i*8 +: 8] == 8'd0) begin
            k = k | (rand_bits() & ({KEY_W{1'b1}} << (i*8 + 8)));
            break;
          end
      end
      if (r < 8) add_cmd(CMD_RENEW, k, $urandom, tick);
      else if (r < 14) add_cmd(CMD_LOOKUP, k, $urandom, tick);
      else if (r < 16) add_cmd(CMD_LIST, rand_bits(), $urandom, tick);
      else if (r == 16) add_cmd(CMD_UNUSED, rand_bits(), $urandom, tick);
      else if (r == 17)
        add_cmd(2'($urandom_range(0, 1)), rand_bits() & ~248'hFF, $urandom, tick);
      else if (r == 18) add_cmd(2'($urandom_range(0, 1)), rand_bits(), $urandom, tick);
      else add_cmd(CMD_RENEW, rand_name($urandom_range(1, 31)), $urandom, tick);
    end
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || req.valid || expected_rsp.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TICK_W-1:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] a;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.cmd = CMD_RENEW;
    req.key_word0 = '0;
    req.key_word1 = '0;
    req.key_word2 = '0;
    req.key_word3 = '0;
    req.freq_in = '0;
    req.now_ticks = '0;
    rsp.ready = 1'b0;
    issued = 0;
    taken = 0;
    errors = 0;
    gap = 0;
    rsp_stall = 0;
    long_hold = 0;
    long_hold_done = 1'b0;
    no_idle = 1'b0;
    shadow_timeout = TIMEOUT_RESET;
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
    for (int i = 0; i < 20; i++) names[i] = rand_name($urandom_range(1, 31));
    names[0] = {{(KEY_W-8){1'b0}}, 8'hFF};
    names[1] = {KEY_BYTES{8'hFF}};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, bad keys, extremes, fill, full, expiry
    no_idle = 1'b1;
    tick = 32'd100;
    add_cmd(CMD_LIST, '0, '0, tick);
    add_cmd(CMD_RENEW, {KEY_BYTES{8'hA5}} & ~248'hFF, 32'hFFFF_FFFF, tick);
    add_cmd(CMD_LOOKUP, names[0], '0, tick);
    add_cmd(CMD_UNUSED, names[0], '0, tick);
    add_cmd(CMD_RENEW, names[0], 32'hFFFF_FFFF, tick);
    add_cmd(CMD_RENEW, names[1], 32'h0, tick);
    a = names[0] | {{(KEY_W-16){1'b1}}, 16'h0000};
    add_cmd(CMD_RENEW, a, 32'h1234_5678, tick + 1);
    add_cmd(CMD_LOOKUP, a, '0, tick + 2);
    add_cmd(CMD_LIST, '0, '0, tick + 2);
    for (int i = 2; i < 16; i++) add_cmd(CMD_RENEW, names[i], $urandom, tick + 3);
    add_cmd(CMD_RENEW, names[16], $urandom, tick + 4);
    add_cmd(CMD_LIST, {KEY_BYTES{8'hFF}}, '0, tick + 4);
    // a tick earlier than every stamp drops the whole table
    add_cmd(CMD_LOOKUP, names[1], '0, 32'd0);
    add_cmd(CMD_LIST, '0, '0, 32'd0);
    drain();
    no_idle = 1'b0;

    write_timeout(32'd1);
    tick = 32'd5000;
    add_random(20);
    drain();

    write_timeout(32'hFFFF_FFFF);
    tick = 32'd0;
    add_random(32);
    drain();

    write_timeout(32'd300);
    add_random(31);
    drain();

    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
